FILE: hdl/golomb_bit_serial_decoder_defines.svh
// Assertion macros used by the decoder core.
// Each macro expects the enclosing module to have clk and arst_n.
`ifndef GOLOMB_BIT_SERIAL_DECODER_DEFINES_SVH
`define GOLOMB_BIT_SERIAL_DECODER_DEFINES_SVH

// Condition that must hold in the same cycle as its trigger.
`define GBSD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must hold in the cycle after its trigger.
`define GBSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/gbsd_pkg.sv
`default_nettype none

package gbsd_pkg;

	// Field and state widths.
	localparam int DIVISOR_BITS = 16;
	localparam int VALUE_BITS   = 32;
	localparam int LOG_BITS     = $clog2(DIVISOR_BITS + 1);
	localparam int CNT_BITS     = $clog2(DIVISOR_BITS);

	localparam logic [DIVISOR_BITS-1:0] DIVISOR_RESET = DIVISOR_BITS'(4);

	// Decoder phase codes.
	localparam logic [1:0] PH_UNARY = 2'd0;
	localparam logic [1:0] PH_REM   = 2'd1;
	localparam logic [1:0] PH_LAST  = 2'd2;

	// One registered input bit.
	typedef struct packed {
		logic vld;
		logic code_bit;
	} in_item_t;

	// One decoded result on its way to the output register.
	typedef struct packed {
		logic                  vld;
		logic [VALUE_BITS-1:0] value;
		logic                  ovf;
	} result_t;

	// Smallest b with 2^b >= m, for m of at least one.
	function automatic logic [LOG_BITS-1:0] ceil_log2(input logic [DIVISOR_BITS-1:0] m);
		logic [LOG_BITS-1:0] b;
		b = '0;
		for (int i = 0; i < DIVISOR_BITS; i++) begin
			if ({1'b0, m} > ((DIVISOR_BITS + 1)'(1) << i)) begin
				b = LOG_BITS'(i + 1);
			end
		end
		return b;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/gbsd_in_reg.sv
`default_nettype none

module gbsd_in_reg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               code_bit,
	input  wire logic               pop,
	output gbsd_pkg::in_item_t      item
);

	logic valid_s1;
	logic bit_s1;

	// A new transaction fits when the slot is empty or being drained.
	assign in_ready = !valid_s1 || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			bit_s1 <= code_bit;
		end
	end

	assign item.vld      = valid_s1;
	assign item.code_bit = bit_s1;

endmodule

`default_nettype wire

FILE: hdl/gbsd_core.sv
`default_nettype none

`include "golomb_bit_serial_decoder_defines.svh"

module gbsd_core (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [gbsd_pkg::DIVISOR_BITS-1:0]     cfg_divisor,
	input  wire logic                                  step,
	input  wire logic                                  code_bit,
	output gbsd_pkg::result_t                          res
);

	localparam int DB = gbsd_pkg::DIVISOR_BITS;
	localparam int VB = gbsd_pkg::VALUE_BITS;
	localparam int LB = gbsd_pkg::LOG_BITS;
	localparam int CB = gbsd_pkg::CNT_BITS;

	logic [DB-1:0] divisor_q;
	logic [1:0]    phase_q,    phase_d;
	logic [VB-1:0] sq_q,       sq_d;
	logic [DB-1:0] ra_q,       ra_d;
	logic [DB-1:0] u_q,        u_d;
	logic [CB-1:0] bl_q,       bl_d;
	logic          ovf_seen_q, ovf_seen_d;
	logic          qp_q,       qp_d;
	logic          odd_base_q, odd_base_d;

	logic [DB-1:0] m_eff;
	logic [LB-1:0] b_eff;
	logic [LB-1:0] b_dec;
	logic [DB:0]   u_full;
	logic [DB-1:0] ra_shift;
	logic [DB:0]   r_last_full;
	logic [CB-1:0] bl_dec;
	logic [VB:0]   sum_u;
	logic          fin;
	logic [DB-1:0] r_fin;
	logic          odd_fin;
	logic [VB:0]   sum_f;
	logic [VB-1:0] v_f;
	logic [VB-1:0] half_f;
	logic          ovf_f;
	logic          odd_f;

	// Divisor register; zero acts as a divisor of one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_q <= gbsd_pkg::DIVISOR_RESET;
		end else if (cfg_we) begin
			divisor_q <= cfg_divisor;
		end
	end

	assign m_eff = (divisor_q == '0) ? DB'(1) : divisor_q;

	// Truncated-binary parameters for the current divisor, captured at the end of the unary run.
	assign b_eff  = gbsd_pkg::ceil_log2(m_eff);
	assign b_dec  = b_eff - LB'(1);
	assign u_full = ((DB + 1)'(1) << b_eff) - {1'b0, m_eff};

	// Remainder shifting and the extended final bit.
	assign ra_shift    = {ra_q[DB-2:0], code_bit};
	assign r_last_full = {ra_q, code_bit} - {1'b0, u_q};
	assign bl_dec      = (bl_q != '0) ? bl_q - CB'(1) : bl_q;

	// Running quotient sum over the one bits.
	assign sum_u = {1'b0, sq_q} + {{(VB + 1 - DB){1'b0}}, m_eff};

	// Next-state logic for one stream bit.
	always_comb begin
		phase_d    = phase_q;
		sq_d       = sq_q;
		ra_d       = ra_q;
		u_d        = u_q;
		bl_d       = bl_q;
		ovf_seen_d = ovf_seen_q;
		qp_d       = qp_q;
		odd_base_d = odd_base_q;
		fin        = 1'b0;
		r_fin      = '0;
		odd_fin    = odd_base_q;
		case (phase_q)
			gbsd_pkg::PH_REM: begin
				ra_d = ra_shift;
				bl_d = bl_dec;
				if (bl_dec == '0) begin
					if (ra_shift < u_q) begin
						fin   = 1'b1;
						r_fin = ra_shift;
					end else begin
						phase_d = gbsd_pkg::PH_LAST;
					end
				end
			end
			gbsd_pkg::PH_LAST: begin
				fin   = 1'b1;
				r_fin = r_last_full[DB-1:0];
			end
			default: begin
				if (code_bit) begin
					qp_d    = qp_q ^ m_eff[0];
					phase_d = gbsd_pkg::PH_UNARY;
					if (sum_u[VB]) begin
						sq_d       = '1;
						ovf_seen_d = 1'b1;
					end else begin
						sq_d = sum_u[VB-1:0];
					end
				end else begin
					odd_base_d = qp_q & m_eff[0];
					u_d        = u_full[DB-1:0];
					if (b_eff == '0) begin
						fin     = 1'b1;
						odd_fin = qp_q & m_eff[0];
					end else begin
						ra_d    = '0;
						bl_d    = b_dec[CB-1:0];
						phase_d = (b_dec == '0) ? gbsd_pkg::PH_LAST : gbsd_pkg::PH_REM;
					end
				end
			end
		endcase
		// A finished codeword starts the next one from a clean state.
		if (fin) begin
			phase_d    = gbsd_pkg::PH_UNARY;
			sq_d       = '0;
			ra_d       = '0;
			bl_d       = '0;
			ovf_seen_d = 1'b0;
			qp_d       = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= gbsd_pkg::PH_UNARY;
			sq_q       <= '0;
			ra_q       <= '0;
			u_q        <= '0;
			bl_q       <= '0;
			ovf_seen_q <= 1'b0;
			qp_q       <= 1'b0;
			odd_base_q <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_d;
			sq_q       <= sq_d;
			ra_q       <= ra_d;
			u_q        <= u_d;
			bl_q       <= bl_d;
			ovf_seen_q <= ovf_seen_d;
			qp_q       <= qp_d;
			odd_base_q <= odd_base_d;
		end
	end

	// Magnitude, saturation and zigzag unmapping of a finished codeword.
	assign sum_f  = {1'b0, sq_q} + {{(VB + 1 - DB){1'b0}}, r_fin};
	assign ovf_f  = ovf_seen_q | sum_f[VB];
	assign odd_f  = odd_fin ^ r_fin[0];
	assign v_f    = sum_f[VB-1:0];
	assign half_f = {1'b0, v_f[VB-1:1]};

	always_comb begin
		res.vld = step & fin;
		res.ovf = ovf_f;
		if (ovf_f) begin
			res.value = odd_f ? {1'b1, {(VB - 1){1'b0}}} : {1'b0, {(VB - 1){1'b1}}};
		end else begin
			res.value = v_f[0] ? ~half_f : half_f;
		end
	end

	`GBSD_ASSERT_SAME(a_rem_count_live, phase_q == gbsd_pkg::PH_REM, bl_q != '0,
		"remainder phase with no bits left")
	`GBSD_ASSERT_SAME(a_sat_full, ovf_seen_q, &sq_q,
		"saturated quotient is not at the limit")
	`GBSD_ASSERT_NEXT(a_clear_after_fin, step && fin,
		phase_q == gbsd_pkg::PH_UNARY && sq_q == '0 && !ovf_seen_q && !qp_q,
		"codeword state not cleared")
	`GBSD_ASSERT_NEXT(a_hold_idle, !step,
		$stable(phase_q) && $stable(sq_q) && $stable(ra_q),
		"state moved without a bit")

endmodule

`default_nettype wire

FILE: hdl/gbsd_out_reg.sv
`default_nettype none

module gbsd_out_reg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire gbsd_pkg::result_t                  res,
	output logic                                    slot_free,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [gbsd_pkg::VALUE_BITS-1:0]  decoded_value,
	output logic                                    overflow
);

	logic                              valid_q;
	logic [gbsd_pkg::VALUE_BITS-1:0]   value_q;
	logic                              ovf_q;

	// The register can take a result when empty or being read this cycle.
	assign slot_free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.vld) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.vld) begin
			value_q <= res.value;
			ovf_q   <= res.ovf;
		end
	end

	assign out_valid     = valid_q;
	assign decoded_value = $signed(value_q);
	assign overflow      = ovf_q;

endmodule

`default_nettype wire

FILE: hdl/golomb_bit_serial_decoder.sv
// Channel   Handshake               Payload
// input     in_valid / in_ready     code_bit (1 bit)
// output    out_valid / out_ready   decoded_value (32 bit signed), overflow
// config    cfg_valid / cfg_ready   golomb_divisor (16 bit, reset 4)
//
// One code bit per clock while the output register has room: a bit is decoded
// while it sits in the input register, and a finished codeword is written to
// the output register at the next edge. A codeword's value is offered from the
// output register once its last bit has left the input register.
// arst_n clears the decoder to the start of a codeword and the divisor to 4.
// While the output register holds an untaken value, one more bit is held at
// the input register and in_ready then drops.
`default_nettype none

module golomb_bit_serial_decoder (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [gbsd_pkg::DIVISOR_BITS-1:0]     golomb_divisor,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic                                  code_bit,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [gbsd_pkg::VALUE_BITS-1:0]     decoded_value,
	output logic                                       overflow
);

	gbsd_pkg::in_item_t item;
	gbsd_pkg::result_t  res;
	logic               slot_free;
	logic               step;

	// The divisor register takes every configuration transaction.
	assign cfg_ready = 1'b1;

	// A held bit is decoded whenever its result has a place to go.
	assign step = item.vld && slot_free;

	gbsd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.code_bit (code_bit),
		.pop      (step),
		.item     (item)
	);

	gbsd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid),
		.cfg_divisor (golomb_divisor),
		.step        (step),
		.code_bit    (item.code_bit),
		.res         (res)
	);

	gbsd_out_reg u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.res           (res),
		.slot_free     (slot_free),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.decoded_value (decoded_value),
		.overflow      (overflow)
	);

endmodule

`default_nettype wire
